/* sv/rvc_pkg.sv */
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared types and codes for the rv32i integer core step block.
// ----------------------------------------------------------------------------
package rvc_pkg;

    localparam logic [31:0] BOOT_PC_RESET = 32'h8000_0000;
    localparam logic [31:0] BOOT_SP_RESET = 32'h8000_0400;

    localparam int XLEN      = 32;
    localparam int REG_AW    = 5;
    localparam int REG_COUNT = 32;

    // item kinds
    localparam logic [1:0] OP_EXEC    = 2'd0;
    localparam logic [1:0] OP_LOAD_RET = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // memory request codes
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    // config register indexes
    localparam logic CFG_BOOT_PC = 1'b0;
    localparam logic CFG_BOOT_SP = 1'b1;

    // major opcodes
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] instr;
        logic [31:0] ldata;
    } item_t;

    typedef struct packed {
        logic        halted;
        logic [31:0] store_data;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic [1:0]  mem_request;
        logic [31:0] next_pc;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] waddr;
        logic [31:0]       wdata;
        logic              clear;
        logic [31:0]       sp_init;
    } rf_wr_t;

endpackage

/* sv/rvc_front.sv */
// ----------------------------------------------------------------------------
// rvc_front
// Two-entry request queue; presents the head item and its source fields.
// ----------------------------------------------------------------------------
module rvc_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rvc_pkg::item_t in_item,
    output logic           head_valid,
    output rvc_pkg::item_t head_item,
    output logic [4:0]     head_rs1,
    output logic [4:0]     head_rs2,
    input  logic           pop
);
    import rvc_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign head_rs1   = head_item.instr[19:15];
    assign head_rs2   = head_item.instr[24:20];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* sv/rvc_regfile.sv */
// ----------------------------------------------------------------------------
// rvc_regfile
// Register file memory with registered reads, per-entry valid bits for
// restart clearing, and bypass of the most recent write.
// ----------------------------------------------------------------------------
module rvc_regfile (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_en,
    input  logic [4:0]      rd_addr1,
    input  logic [4:0]      rd_addr2,
    input  rvc_pkg::rf_wr_t wr,
    output logic [31:0]     rs1_val,
    output logic [31:0]     rs2_val
);
    import rvc_pkg::*;

    logic [31:0]          mem [REG_COUNT];
    logic [31:0]          rd1_reg, rd2_reg;
    logic [REG_AW-1:0]    ra1_reg, ra2_reg;
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0]          sp_reg;
    logic                 fwd_valid_reg;
    logic [REG_AW-1:0]    fwd_addr_reg;
    logic [31:0]          fwd_data_reg;

    function automatic logic [31:0] resolve(input logic [REG_AW-1:0] ra,
                                            input logic [31:0] rdata);
        logic [31:0] v;
        if (ra == '0) begin
            v = '0;
        end else if (fwd_valid_reg && fwd_addr_reg == ra) begin
            v = fwd_data_reg;
        end else if (valid_reg[ra]) begin
            v = rdata;
        end else if (ra == REG_AW'(2)) begin
            v = sp_reg;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    assign rs1_val = resolve(ra1_reg, rd1_reg);
    assign rs2_val = resolve(ra2_reg, rd2_reg);

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
        if (rd_en) begin
            rd1_reg <= mem[rd_addr1];
            rd2_reg <= mem[rd_addr2];
            ra1_reg <= rd_addr1;
            ra2_reg <= rd_addr2;
        end
        if (wr.we) begin
            fwd_addr_reg <= wr.waddr;
            fwd_data_reg <= wr.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            sp_reg        <= BOOT_SP_RESET;
            fwd_valid_reg <= 1'b0;
        end else if (wr.clear) begin
            valid_reg     <= '0;
            sp_reg        <= wr.sp_init;
            fwd_valid_reg <= 1'b0;
        end else if (wr.we) begin
            valid_reg[wr.waddr] <= 1'b1;
            fwd_valid_reg       <= 1'b1;
        end
    end

endmodule

/* sv/rvc_back.sv */
// ----------------------------------------------------------------------------
// rvc_back
// Execute stage: decodes the item, updates pc and register state, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module rvc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             head_valid,
    input  rvc_pkg::item_t   head_item,
    input  logic [4:0]       head_rs1,
    input  logic [4:0]       head_rs2,
    output logic             pop,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_wdata,
    output logic             res_valid,
    input  logic             res_ready,
    output rvc_pkg::result_t res
);
    import rvc_pkg::*;

    item_t       e_item_reg;
    logic        e_valid_reg;
    logic        e_fire;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] boot_pc_reg, boot_sp_reg;
    logic [4:0]  pend_dest_reg, pend_dest_next;
    logic [2:0]  pend_kind_reg, pend_kind_next;
    logic        m_valid_reg;
    result_t     m_data_reg, r;
    rf_wr_t      wr;
    logic [31:0] a, b;

    logic [31:0] w, immi, imms, immb, immj, immu, ldv;
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic        wen, taken;
    logic [31:0] wdat;

    assign e_fire    = e_valid_reg && (!m_valid_reg || res_ready);
    assign pop       = head_valid && (!e_valid_reg || e_fire);
    assign res_valid = m_valid_reg;
    assign res       = m_data_reg;

    rvc_regfile u_rf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (pop),
        .rd_addr1 (head_rs1),
        .rd_addr2 (head_rs2),
        .wr       (wr),
        .rs1_val  (a),
        .rs2_val  (b)
    );

    always_comb begin
        w    = e_item_reg.instr;
        opc  = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        f7   = w[31:25];
        immi = {{20{w[31]}}, w[31:20]};
        imms = {{20{w[31]}}, w[31:25], w[11:7]};
        immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        immu = {w[31:12], 12'd0};

        unique case (pend_kind_reg)
            3'd0:    ldv = {{24{e_item_reg.ldata[7]}}, e_item_reg.ldata[7:0]};
            3'd1:    ldv = {{16{e_item_reg.ldata[15]}}, e_item_reg.ldata[15:0]};
            3'd4:    ldv = {24'd0, e_item_reg.ldata[7:0]};
            3'd5:    ldv = {16'd0, e_item_reg.ldata[15:0]};
            default: ldv = e_item_reg.ldata;
        endcase

        r              = '0;
        r.next_pc      = pc_reg;
        r.mem_request  = MEM_NONE;
        wen            = 1'b0;
        wdat           = '0;
        taken          = 1'b0;
        pend_dest_next = pend_dest_reg;
        pend_kind_next = pend_kind_reg;
        wr             = '0;
        wr.waddr       = rd;
        wr.sp_init     = boot_sp_reg;

        unique case (e_item_reg.op)
            OP_EXEC: begin
                if (w == '0) begin
                    r.halted = 1'b1;
                end else begin
                    r.next_pc = pc_reg + 32'd4;
                    unique case (opc)
                        OPC_REG, OPC_IMM: begin
                            logic [31:0] op2;
                            op2 = (opc == OPC_REG) ? b : immi;
                            wen = 1'b1;
                            unique case (f3)
                                3'd0: begin
                                    if (opc == OPC_IMM || f7 == F7_BASE) wdat = a + op2;
                                    else if (f7 == F7_ALT) wdat = a - op2;
                                    else wen = 1'b0;
                                end
                                3'd1: wdat = a << op2[4:0];
                                3'd2: wdat = {31'd0, $signed(a) < $signed(op2)};
                                3'd3: wdat = {31'd0, a < op2};
                                3'd4: wdat = a ^ op2;
                                3'd5: begin
                                    if (f7 == F7_BASE) wdat = a >> op2[4:0];
                                    else if (f7 == F7_ALT) wdat = 32'($signed(a) >>> op2[4:0]);
                                    else wen = 1'b0;
                                end
                                3'd6: wdat = a | op2;
                                default: wdat = a & op2;
                            endcase
                        end
                        OPC_LOAD: begin
                            if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 ||
                                f3 == 3'd4 || f3 == 3'd5) begin
                                r.mem_request  = MEM_READ;
                                r.mem_address  = a + immi;
                                r.mem_size     = {1'b0, 1'b0} | f3[1:0];
                                pend_dest_next = rd;
                                pend_kind_next = f3;
                            end
                        end
                        OPC_STORE: begin
                            if (f3 <= 3'd2) begin
                                r.mem_request = MEM_WRITE;
                                r.mem_address = a + imms;
                                r.mem_size    = f3[1:0];
                                r.store_data  = b;
                            end
                        end
                        OPC_BRANCH: begin
                            unique case (f3)
                                3'd0:    taken = (a == b);
                                3'd1:    taken = (a != b);
                                3'd4:    taken = $signed(a) < $signed(b);
                                3'd5:    taken = !($signed(a) < $signed(b));
                                3'd6:    taken = (a < b);
                                3'd7:    taken = (a >= b);
                                default: taken = 1'b0;
                            endcase
                            if (taken) r.next_pc = pc_reg + immb;
                        end
                        OPC_JAL: begin
                            wen       = 1'b1;
                            wdat      = pc_reg + 32'd4;
                            r.next_pc = pc_reg + immj;
                        end
                        OPC_JALR: begin
                            if (f3 == 3'd0) begin
                                wen       = 1'b1;
                                wdat      = pc_reg + 32'd4;
                                r.next_pc = (a + immi) & ~32'd1;
                            end
                        end
                        OPC_LUI: begin
                            wen  = 1'b1;
                            wdat = immu;
                        end
                        OPC_AUIPC: begin
                            wen  = 1'b1;
                            wdat = pc_reg + immu;
                        end
                        default: ;
                    endcase
                end
            end
            OP_LOAD_RET: begin
                wen            = 1'b1;
                wr.waddr       = pend_dest_reg;
                wdat           = ldv;
                pend_dest_next = '0;
            end
            OP_RESTART: begin
                r.next_pc      = boot_pc_reg;
                wr.clear       = e_fire;
                pend_dest_next = '0;
                pend_kind_next = '0;
            end
            default: ;
        endcase

        // x0 writes are dropped
        wr.we    = e_fire && wen && (wr.waddr != '0);
        wr.wdata = wdat;
        pc_next  = r.next_pc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            pc_reg        <= BOOT_PC_RESET;
            boot_pc_reg   <= BOOT_PC_RESET;
            boot_sp_reg   <= BOOT_SP_RESET;
            pend_dest_reg <= '0;
            pend_kind_reg <= '0;
        end else begin
            if (pop) begin
                e_valid_reg <= 1'b1;
            end else if (e_fire) begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire) begin
                m_valid_reg   <= 1'b1;
                pc_reg        <= pc_next;
                pend_dest_reg <= pend_dest_next;
                pend_kind_reg <= pend_kind_next;
            end else if (res_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_index == CFG_BOOT_PC) boot_pc_reg <= cfg_wdata;
                else boot_sp_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            e_item_reg <= head_item;
        end
        if (e_fire) begin
            m_data_reg <= r;
        end
    end

endmodule

/* sv/rv32i_integer_core_step.sv */
// path: an accepted request is held in a queue slot, then its operands are read
// into registers, then it executes into the output register
// throughput: one request per cycle while m_tready is high, set by the single execute
// stage and its registered register-file read with bypass of the previous write
// reset: synchronous active-low aresetn; pc = 0x80000000, x2 = 0x80000400,
// other registers zero; restart clears the register file via valid bits at once
// ----------------------------------------------------------------------------
// rv32i_integer_core_step
// RV32I core step: queue front end, execute back end with register file.
// ----------------------------------------------------------------------------
module rv32i_integer_core_step (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // instr_word[31:0], load_data[63:32]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // next_pc[31:0], mem_request[33:32],
                                    // mem_address[65:34], mem_size[67:66],
                                    // store_data[99:68], halted[100]
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import rvc_pkg::*;

    item_t      in_item, head_item;
    result_t    res;
    logic       head_valid, pop;
    logic [4:0] head_rs1, head_rs2;

    assign in_item.op    = s_tuser;
    assign in_item.instr = s_tdata[31:0];
    assign in_item.ldata = s_tdata[63:32];

    rvc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_rs1   (head_rs1),
        .head_rs2   (head_rs2),
        .pop        (pop)
    );

    rvc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_rs1   (head_rs1),
        .head_rs2   (head_rs2),
        .pop        (pop),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'd0, res};

endmodule

/* verif/tb_rv32i_integer_core_step.sv */
// ----------------------------------------------------------------------------
// tb_rv32i_integer_core_step
// Self-checking bench for the rv32i core step block: directed table of
// instructions followed by random programs, each result compared against a
// behavioral model of the core with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_rv32i_integer_core_step;
    import rvc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM     = 400;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] instr;
        logic [31:0] ldata;
        bit          fixed;
        logic [31:0] exp_pc;
        logic [1:0]  exp_req;
        logic        exp_halt;
    } vec_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_wdata = '0;

    rv32i_integer_core_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // core model state
    logic [31:0] gpr [32];
    logic [31:0] pc_q;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;
    logic [31:0] boot_pc_q, boot_sp_q;

    result_t     step_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 0;
    bit          hold_off = 0;
    vec_t        fixed_q [$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = 32'h1 << (bits - 1);
        v = (bits >= 32) ? v : (v & ((32'h1 << bits) - 1));
        return (v ^ m) - m;
    endfunction

    function automatic logic slt(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic void put(input logic [4:0] rd, input logic [31:0] v);
        if (rd != 0) gpr[rd] = v;
    endfunction

    function automatic result_t core_step(input logic [1:0] op, input logic [31:0] w,
                                          input logic [31:0] ld);
        result_t r;
        logic [6:0]  opc, f7;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [31:0] a, b, ii, is, ib, ij, iu, npc, v;
        logic        t;
        r = '0;
        npc = pc_q;
        opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
        a = gpr[w[19:15]]; b = gpr[w[24:20]];
        ii = sx({20'b0, w[31:20]}, 12);
        is = sx({20'b0, w[31:25], w[11:7]}, 12);
        ib = sx({19'b0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        ij = sx({11'b0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
        iu = {w[31:12], 12'b0};
        if (op == OP_EXEC) begin
            if (w == 0) begin
                r.halted = 1'b1;
            end else begin
                npc = pc_q + 4;
                case (opc)
                    OPC_REG, OPC_IMM: begin
                        if (opc == OPC_IMM) b = ii;
                        case (f3)
                            3'd0: begin
                                if (opc == OPC_IMM) put(rd, a + b);
                                else if (f7 == F7_BASE) put(rd, a + b);
                                else if (f7 == F7_ALT) put(rd, a - b);
                            end
                            3'd1: put(rd, a << b[4:0]);
                            3'd2: put(rd, {31'b0, slt(a, b)});
                            3'd3: put(rd, {31'b0, a < b});
                            3'd4: put(rd, a ^ b);
                            3'd5: begin
                                if (f7 == F7_BASE) put(rd, a >> b[4:0]);
                                else if (f7 == F7_ALT) put(rd, $unsigned($signed(a) >>> b[4:0]));
                            end
                            3'd6: put(rd, a | b);
                            default: put(rd, a & b);
                        endcase
                    end
                    OPC_LOAD: if (f3 inside {3'd0, 3'd1, 3'd2, 3'd4, 3'd5}) begin
                        r.mem_request = MEM_READ;
                        r.mem_address = a + ii;
                        r.mem_size = f3[1:0];
                        ld_dest = rd;
                        ld_kind = f3;
                    end
                    OPC_STORE: if (f3 <= 2) begin
                        r.mem_request = MEM_WRITE;
                        r.mem_address = a + is;
                        r.mem_size = f3[1:0];
                        r.store_data = b;
                    end
                    OPC_BRANCH: begin
                        case (f3)
                            3'd0: t = a == b;
                            3'd1: t = a != b;
                            3'd4: t = slt(a, b);
                            3'd5: t = !slt(a, b);
                            3'd6: t = a < b;
                            3'd7: t = a >= b;
                            default: t = 1'b0;
                        endcase
                        if (t) npc = pc_q + ib;
                    end
                    OPC_JAL: begin
                        put(rd, pc_q + 4);
                        npc = pc_q + ij;
                    end
                    OPC_JALR: if (f3 == 0) begin
                        npc = (a + ii) & ~32'h1;
                        put(rd, pc_q + 4);
                    end
                    OPC_LUI: put(rd, iu);
                    OPC_AUIPC: put(rd, pc_q + iu);
                    default: ;
                endcase
            end
        end else if (op == OP_LOAD_RET) begin
            case (ld_kind)
                3'd0: v = sx(ld, 8);
                3'd1: v = sx(ld, 16);
                3'd4: v = ld & 32'hFF;
                3'd5: v = ld & 32'hFFFF;
                default: v = ld;
            endcase
            put(ld_dest, v);
            ld_dest = 0;
        end else if (op == OP_RESTART) begin
            foreach (gpr[i]) gpr[i] = '0;
            gpr[2] = boot_sp_q;
            npc = boot_pc_q;
            ld_dest = 0;
            ld_kind = 0;
        end
        pc_q = npc;
        r.next_pc = npc;
        return r;
    endfunction

    // instruction builders
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
        input logic [4:0] rs1, input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
        input logic [2:0] f3, input logic [4:0] rd, input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [4:0] rreg();
        return (($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7)));
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [6:0] opcs [9];
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
        logic [31:0] w;
        opcs = '{OPC_REG, OPC_IMM, OPC_LOAD, OPC_STORE, OPC_BRANCH, OPC_JAL,
                 OPC_JALR, OPC_LUI, OPC_AUIPC};
        w = $urandom;
        if ($urandom_range(0, 19) == 0) return w;
        opc = opcs[$urandom_range(0, 8)];
        f3 = 3'($urandom);
        f7 = ($urandom_range(0, 7) == 0) ? 7'($urandom) : ($urandom_range(0, 1) ? F7_ALT : F7_BASE);
        if (opc == OPC_IMM && f3 != 3'd5 && $urandom_range(0, 1)) f7 = 7'($urandom);
        if (opc == OPC_IMM && f3 == 3'd5) w[24:20] = 5'($urandom);
        return {f7, (opc == OPC_IMM || opc == OPC_JALR || opc == OPC_LOAD)
                    ? w[24:20] : rreg(), rreg(), f3, rreg(), opc};
    endfunction

    // stimulus table of directed items
    task automatic add_row(input logic [1:0] op, input logic [31:0] w, input logic [31:0] ld,
                           input bit fx = 0, input logic [31:0] epc = 0,
                           input logic [1:0] ereq = MEM_NONE, input logic eh = 0);
        vec_t v;
        v.op = op; v.instr = w; v.ldata = ld; v.fixed = fx;
        v.exp_pc = epc; v.exp_req = ereq; v.exp_halt = eh;
        fixed_q.push_back(v);
    endtask

    task automatic send(input logic [1:0] op, input logic [31:0] w, input logic [31:0] ld,
                        input bit fx, input logic [31:0] epc, input logic [1:0] ereq,
                        input logic eh);
        result_t r;
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {ld, w};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = core_step(op, w, ld);
        if (fx) begin
            if (r.next_pc !== epc || r.mem_request !== ereq || r.halted !== eh)
                report("table row", r.next_pc, epc);
        end
        step_q.push_back(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (step_q.size() != 0 && cycles < LIMIT_CYCLES) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] v);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_BOOT_PC) boot_pc_q = v; else boot_sp_q = v;
        @(posedge aclk);
    endtask

    // random program segment: mostly real instructions, loads mostly followed by returns
    task automatic random_burst(input int n);
        logic [31:0] w;
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 39))
                0:       send(OP_RESTART, $urandom, $urandom, 0, 0, 0, 0);
                1:       send(2'd3, $urandom, $urandom, 0, 0, 0, 0);
                2:       send(OP_EXEC, 32'h0, $urandom, 0, 0, 0, 0);
                3, 4, 5: send(OP_LOAD_RET, $urandom, $urandom, 0, 0, 0, 0);
                default: begin
                    w = rand_instr();
                    send(OP_EXEC, w, $urandom, 0, 0, 0, 0);
                    if (w[6:0] == OPC_LOAD && $urandom_range(0, 3) != 0)
                        send(OP_LOAD_RET, $urandom, $urandom, 0, 0, 0, 0);
                end
            endcase
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[100:0]);
            if (step_q.size() == 0) begin
                report("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = step_q.pop_front();
                if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
                if (got.mem_request !== want.mem_request)
                    report("mem_request", 32'(got.mem_request), 32'(want.mem_request));
                if (got.mem_address !== want.mem_address)
                    report("mem_address", got.mem_address, want.mem_address);
                if (got.mem_size !== want.mem_size)
                    report("mem_size", 32'(got.mem_size), 32'(want.mem_size));
                if (got.store_data !== want.store_data)
                    report("store_data", got.store_data, want.store_data);
                if (got.halted !== want.halted)
                    report("halted", 32'(got.halted), 32'(want.halted));
            end
        end
    end

    // receiver stalls, with one long hold-off
    initial begin
        int gap;
        while (1) begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 18);
                repeat (gap - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int i;
        foreach (gpr[j]) gpr[j] = '0;
        boot_pc_q = BOOT_PC_RESET; boot_sp_q = BOOT_SP_RESET;
        gpr[2] = BOOT_SP_RESET;
        pc_q = BOOT_PC_RESET; ld_dest = 0; ld_kind = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        add_row(OP_EXEC, 32'h0, 32'h0, 1, BOOT_PC_RESET, MEM_NONE, 1);
        add_row(OP_LOAD_RET, 32'h0, 32'hFFFF_FFFF, 1, BOOT_PC_RESET, MEM_NONE, 0);
        add_row(OP_EXEC, 32'hFFFF_FFFF, 32'h0, 1, BOOT_PC_RESET + 4, MEM_NONE, 0);
        add_row(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, BOOT_PC_RESET + 4, MEM_NONE, 0);
        add_row(OP_EXEC, enc_i(12'h800, 5'd0, 3'd0, 5'd1, OPC_IMM), 0);     // addi x1,-2048
        add_row(OP_EXEC, enc_i(12'h7FF, 5'd1, 3'd0, 5'd3, OPC_IMM), 0);
        add_row(OP_EXEC, enc_i(12'h41F, 5'd1, 3'd5, 5'd4, OPC_IMM), 0);     // srai 31
        add_row(OP_EXEC, enc_i(12'h01F, 5'd1, 3'd5, 5'd5, OPC_IMM), 0);     // srli 31
        add_row(OP_EXEC, enc_i(12'hC01, 5'd1, 3'd5, 5'd5, OPC_IMM), 0);     // bad funct7
        add_row(OP_EXEC, enc_r(F7_ALT, 5'd1, 5'd3, 3'd0, 5'd6, OPC_REG), 0);
        add_row(OP_EXEC, enc_r(7'h7F, 5'd1, 5'd3, 3'd0, 5'd6, OPC_REG), 0);
        add_row(OP_EXEC, enc_r(F7_BASE, 5'd1, 5'd3, 3'd2, 5'd0, OPC_REG), 0); // x0 dest
        add_row(OP_EXEC, 32'hFFFFF0B7, 0);                                    // lui x1
        add_row(OP_EXEC, 32'hFFFFF117, 0);                                    // auipc x2
        add_row(OP_EXEC, enc_i(12'hFFF, 5'd2, 3'd0, 5'd7, OPC_LOAD), 0);      // lb
        add_row(OP_LOAD_RET, 0, 32'h0000_0080);
        add_row(OP_EXEC, enc_i(12'h004, 5'd2, 3'd5, 5'd8, OPC_LOAD), 0);      // lhu
        add_row(OP_LOAD_RET, 0, 32'hFFFF_8001);
        add_row(OP_EXEC, enc_i(12'h000, 5'd0, 3'd3, 5'd8, OPC_LOAD), 0);      // bad funct3
        add_row(OP_EXEC, {7'h7F, 5'd7, 5'd2, 3'd2, 5'h1F, OPC_STORE}, 0);
        add_row(OP_EXEC, {7'h00, 5'd7, 5'd7, 3'd0, 5'd8, OPC_BRANCH}, 0);    // beq taken
        add_row(OP_EXEC, {7'h7F, 5'd7, 5'd8, 3'd7, 5'h1F, OPC_BRANCH}, 0);
        add_row(OP_EXEC, 32'h800000EF, 0);                                    // jal back
        add_row(OP_EXEC, enc_i(12'h001, 5'd1, 3'd0, 5'd1, OPC_JALR), 0);
        add_row(OP_RESTART, 0, 0, 1, BOOT_PC_RESET, MEM_NONE, 0);
        foreach (fixed_q[k])
            send(fixed_q[k].op, fixed_q[k].instr, fixed_q[k].ldata, fixed_q[k].fixed,
                 fixed_q[k].exp_pc, fixed_q[k].exp_req, fixed_q[k].exp_halt);

        // random phases across config settings, extremes included
        for (i = 0; i < 4; i++) begin
            drain();
            case (i)
                0: begin write_cfg(CFG_BOOT_PC, 32'h0); write_cfg(CFG_BOOT_SP, 32'hFFFF_FFFF); end
                1: begin write_cfg(CFG_BOOT_PC, 32'hFFFF_FFFC); write_cfg(CFG_BOOT_SP, 32'h0); end
                default: begin
                    write_cfg(CFG_BOOT_PC, $urandom);
                    write_cfg(CFG_BOOT_SP, $urandom);
                end
            endcase
            send(OP_RESTART, $urandom, $urandom, 0, 0, 0, 0);
            if (i == 1) hold_off = 1;
            if (i == 3) calm = 1;
            random_burst(N_RANDOM / 4);
        end

        drain();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* sim.f */
sv/rvc_pkg.sv
sv/rvc_front.sv
sv/rvc_regfile.sv
sv/rvc_back.sv
sv/rv32i_integer_core_step.sv
verif/tb_rv32i_integer_core_step.sv
